// ===== sv/afd_pkg.sv =====
package afd_pkg;

  // Default number of ASCII characters in the length field
  localparam int LENGTH_DIGITS = 14;

  // Frame marker "IDOOR"
  localparam logic [2:0] MARKER_LEN = 3'd5;
  localparam logic [7:0] MARKER_FIRST = 8'h49;

  // Characters of the length field
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // One result word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
  } result_t;

  // Marker byte at a given match position
  function automatic logic [7:0] marker_at(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h49;
      3'd1: b = 8'h44;
      3'd2: b = 8'h4F;
      3'd3: b = 8'h4F;
      3'd4: b = 8'h52;
      default: b = 8'h49;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/ascii_length_frame_deframer.sv =====
// ASCII length-prefixed frame deframer.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per
// word. The block hunts for the marker "IDOOR", skips the byte after it,
// reads LENGTH_DIGITS ASCII decimal characters as the payload length, then
// passes that many payload bytes out.
// Output channel: out_valid / out_stall carry payload_byte, last_of_frame
// (final byte of a frame) and empty_frame (a frame of length zero, given as
// one word with payload_byte zero and last_of_frame set).
// Throughput: one input byte per cycle while in_stall is low. A result word is
// registered in the output buffer when the byte that causes it is accepted;
// marker, skipped and length bytes give no word.
// When the receiver stalls, the output register holds its word and one more
// result goes into a skid register; in_stall rises only while that skid
// register is occupied, and falls once the output drains it.
// Reset (rst, synchronous) empties both output registers and returns the
// block to hunting for the marker.
module ascii_length_frame_deframer #(
  parameter int LENGTH_DIGITS = afd_pkg::LENGTH_DIGITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       last_of_frame,
  output logic       empty_frame
);

  logic             take;
  logic             res_valid;
  afd_pkg::result_t res;
  logic             buf_full;
  afd_pkg::result_t out_data;

  // Accept a byte whenever the skid word is free
  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  afd_core #(
    .LENGTH_DIGITS(LENGTH_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  afd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  assign payload_byte  = out_data.payload_byte;
  assign last_of_frame = out_data.last_of_frame;
  assign empty_frame   = out_data.empty_frame;

endmodule

// ===== sv/afd_core.sv =====
module afd_core #(
  parameter int LENGTH_DIGITS = afd_pkg::LENGTH_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output afd_pkg::result_t  res
);

  localparam int POS_W = $clog2(LENGTH_DIGITS + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LENGTH_DIGITS);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  phase_t           phase, phase_next;
  logic [2:0]       marker_matched, marker_matched_next;
  logic [POS_W-1:0] header_position, header_position_next;
  logic [31:0]      length_accumulator, length_accumulator_next;
  logic             length_bad, length_bad_next;
  logic             digits_started, digits_started_next;
  logic [31:0]      payload_remaining, payload_remaining_next;

  logic        is_digit;
  logic [35:0] acc_wide;
  logic [35:0] acc_prod;
  logic [31:0] frame_len;
  logic [2:0]  match_base;
  logic [2:0]  match_new;

  // Multiply the accumulator by ten and add the digit
  assign is_digit = (rx_byte >= afd_pkg::CHAR_ZERO) && (rx_byte <= afd_pkg::CHAR_NINE);
  assign acc_wide = {4'b0000, length_accumulator};
  assign acc_prod = (acc_wide << 3) + (acc_wide << 1) + {32'd0, rx_byte[3:0]};

  // Work out the next state and the result for the byte on offer
  always_comb begin
    phase_next              = phase;
    marker_matched_next     = marker_matched;
    header_position_next    = header_position;
    length_accumulator_next = length_accumulator;
    length_bad_next         = length_bad;
    digits_started_next     = digits_started;
    payload_remaining_next  = payload_remaining;
    res_valid               = 1'b0;
    res.payload_byte        = rx_byte;
    res.last_of_frame       = 1'b0;
    res.empty_frame         = 1'b0;
    frame_len               = 32'd0;
    match_base              = 3'd0;
    match_new               = 3'd0;

    case (phase)
      PH_HEADER: begin
        // Skip the first header byte, then take length characters
        if (header_position != '0) begin
          if (is_digit) begin
            digits_started_next = 1'b1;
            if (acc_prod[35:32] != 4'd0) begin
              length_bad_next = 1'b1;
            end else begin
              length_accumulator_next = acc_prod[31:0];
            end
          end else if (!(rx_byte == afd_pkg::CHAR_SPACE && !digits_started)) begin
            length_bad_next = 1'b1;
          end
        end
        if (header_position >= POS_LAST) begin
          header_position_next = '0;
          frame_len = length_bad_next ? 32'd0 : length_accumulator_next;
          if (frame_len == 32'd0) begin
            phase_next        = PH_HUNT;
            res_valid         = 1'b1;
            res.payload_byte  = 8'd0;
            res.last_of_frame = 1'b1;
            res.empty_frame   = 1'b1;
          end else begin
            payload_remaining_next = frame_len;
            phase_next             = PH_PAYLOAD;
          end
        end else begin
          header_position_next = header_position + POS_W'(1);
        end
      end

      PH_PAYLOAD: begin
        // Pass the byte and count down
        payload_remaining_next = payload_remaining - 32'd1;
        res_valid              = 1'b1;
        res.last_of_frame      = (payload_remaining == 32'd1);
        if (payload_remaining == 32'd1) begin
          phase_next = PH_HUNT;
        end
      end

      default: begin
        // Hunt for the marker; the unused phase code lands here too
        phase_next = PH_HUNT;
        match_base = (marker_matched >= afd_pkg::MARKER_LEN) ? 3'd0 : marker_matched;
        if (rx_byte == afd_pkg::marker_at(match_base)) begin
          match_new = match_base + 3'd1;
        end else begin
          match_new = (rx_byte == afd_pkg::MARKER_FIRST) ? 3'd1 : 3'd0;
        end
        marker_matched_next = match_new;
        if (match_new == afd_pkg::MARKER_LEN) begin
          marker_matched_next     = 3'd0;
          phase_next              = PH_HEADER;
          header_position_next    = '0;
          length_accumulator_next = 32'd0;
          length_bad_next         = 1'b0;
          digits_started_next     = 1'b0;
        end
      end
    endcase
  end

  // Hold state; advance only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      marker_matched     <= 3'd0;
      header_position    <= '0;
      length_accumulator <= 32'd0;
      length_bad         <= 1'b0;
      digits_started     <= 1'b0;
      payload_remaining  <= 32'd0;
    end else if (take) begin
      phase              <= phase_next;
      marker_matched     <= marker_matched_next;
      header_position    <= header_position_next;
      length_accumulator <= length_accumulator_next;
      length_bad         <= length_bad_next;
      digits_started     <= digits_started_next;
      payload_remaining  <= payload_remaining_next;
    end
  end

endmodule

// ===== sv/afd_outbuf.sv =====
module afd_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  afd_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  output afd_pkg::result_t  out_data,
  input  logic              out_stall
);

  logic             skid_valid;
  afd_pkg::result_t skid_data;
  logic             pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Control: output register plus one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Data: push only arrives while the skid word is free
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule
